FILE: sv/nfct_pkg.sv
package nfct_pkg;

   localparam int ADDR_W     = 32;
   localparam int PORT_W     = 16;
   localparam int PROTO_W    = 8;
   localparam int TIME_W     = 64;
   localparam int COUNT_W    = 32;
   localparam int CSR_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 264;
   localparam int RSP_USER_W = 3;
   localparam int KEY_W      = 2 * ADDR_W + 2 * PORT_W + PROTO_W;

   localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
   localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

   localparam logic KIND_SNAT = 1'b0;
   localparam logic KIND_DNAT = 1'b1;

   localparam logic [CSR_W-1:0] POD_BASE_RST = 32'h0AF4_0000;
   localparam logic [CSR_W-1:0] POD_MASK_RST = 32'hFFFF_0000;
   localparam logic [CSR_W-1:0] SVC_BASE_RST = 32'h0A60_0000;
   localparam logic [CSR_W-1:0] SVC_MASK_RST = 32'hFFF0_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_POD_BASE = 3'd0,
      REG_POD_MASK = 3'd1,
      REG_SVC_BASE = 3'd2,
      REG_SVC_MASK = 3'd3
   } csr_reg_type;

   typedef struct packed {
      logic [TIME_W-1:0]  time_stamp;
      logic [PROTO_W-1:0] proto_num;
      logic [PORT_W-1:0]  dst_port;
      logic [PORT_W-1:0]  src_port;
      logic [ADDR_W-1:0]  dst_addr;
      logic [ADDR_W-1:0]  src_addr;
   } header_type;

   typedef struct packed {
      logic                          kind;
      logic [COUNT_W-1:0]            pkt_count;
      logic [TIME_W-1:0]             last_time;
      logic [TIME_W-1:0]             first_time;
      logic [2*PORT_W+PROTO_W-1:0]   ports_proto;
      logic [2*ADDR_W-1:0]           addr_pair;
   } flow_entry_type;

   typedef struct packed {
      logic data_en;
      logic valid_en;
      logic valid_bit;
   } mem_wr_type;

   typedef struct packed {
      logic               table_full;
      logic               new_flow;
      logic               nat_kind;
      logic [COUNT_W-1:0] flow_count;
      logic [TIME_W-1:0]  flow_start_time;
      header_type         hdr;
   } result_type;

endpackage

FILE: sv/nat_flow_classifier_tracker.sv
// Classifies TCP and UDP headers as source or destination NAT against the pod and service
// prefixes and keeps a per-flow first-seen time and packet count in a table of FLOW_ENTRIES
// flows. A header is taken while the block is idle; one that is not classified gives no result
// and the block stays ready for the next header. A classified header then walks a linear-probe
// chain through the flow memory, one slot per cycle behind its registered read, until it finds
// its key or an empty slot; it visits at most FLOW_ENTRIES slots, all of them when the table is
// full. After reset a clearing pass over all FLOW_ENTRIES slots runs before the
// first header is taken; register writes are taken during it. A finished result waits in an
// output register while the next header is taken.
module nat_flow_classifier_tracker
   import nfct_pkg::*;
#(
   parameter int FLOW_ENTRIES = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // src_addr, dst_addr, src_port, dst_port, proto_num, time_stamp
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_src_addr, out_dst_addr, out_src_port, out_dst_port, out_proto, out_time,
   // flow_start_time, flow_count
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // nat_kind, new_flow, table_full
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   localparam int IDX_W = $clog2(FLOW_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE
   } state_type;

   function automatic logic [IDX_W-1:0] flow_hash(input logic [KEY_W-1:0] key);
      logic [IDX_W-1:0] h;
      h = '0;
      for (int i = 0; i < KEY_W; i++) begin
         h[i % IDX_W] = h[i % IDX_W] ^ key[i];
      end
      if ({1'b0, h} >= (IDX_W + 1)'(FLOW_ENTRIES)) begin
         h = h - IDX_W'(FLOW_ENTRIES);
      end
      return h;
   endfunction

   state_type        state_ff;
   logic [IDX_W-1:0] clr_idx_ff;
   logic [IDX_W-1:0] probe_idx_ff;
   logic [IDX_W-1:0] probe_cnt_ff;
   header_type       hdr_ff;
   logic             kind_ff;
   result_type       rsp_ff;
   logic             rsp_valid_ff;
   logic [CSR_W-1:0] pod_base_ff;
   logic [CSR_W-1:0] pod_mask_ff;
   logic [CSR_W-1:0] svc_base_ff;
   logic [CSR_W-1:0] svc_mask_ff;

   header_type       hdr_in;
   logic             src_pod;
   logic             dst_pod;
   logic             dst_svc;
   logic             snat;
   logic             classified;
   logic             accept;
   logic             rd_valid;
   flow_entry_type   rd_entry;
   logic             key_match;
   logic             hit;
   logic             empty;
   logic             done;
   logic             out_free;
   logic             finish;
   logic [IDX_W-1:0] next_idx;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   mem_wr_type       wr;
   flow_entry_type   wr_entry;
   result_type       rsp_in;

   always_comb begin
      hdr_in     = header_type'(req_tdata);
      src_pod    = (hdr_in.src_addr & pod_mask_ff) == pod_base_ff;
      dst_pod    = (hdr_in.dst_addr & pod_mask_ff) == pod_base_ff;
      dst_svc    = (hdr_in.dst_addr & svc_mask_ff) == svc_base_ff;
      snat       = src_pod && !dst_pod && !dst_svc;
      classified = ((hdr_in.proto_num == PROTO_TCP) || (hdr_in.proto_num == PROTO_UDP))
                   && (snat || dst_svc);
      accept     = req_tvalid && req_tready;

      key_match = (rd_entry.addr_pair == {hdr_ff.src_addr, hdr_ff.dst_addr}) &&
                  (rd_entry.ports_proto == {hdr_ff.src_port, hdr_ff.dst_port, hdr_ff.proto_num});
      hit      = rd_valid && key_match;
      empty    = !rd_valid;
      done     = hit || empty || (probe_cnt_ff == LAST_IDX);
      out_free = !rsp_valid_ff || rsp_tready;
      finish   = (state_ff == ST_PROBE) && done && out_free;
      next_idx = (probe_idx_ff == LAST_IDX) ? '0 : probe_idx_ff + IDX_W'(1);

      if (state_ff == ST_IDLE) begin
         rd_addr = flow_hash({hdr_in.src_addr, hdr_in.dst_addr, hdr_in.src_port,
                              hdr_in.dst_port, hdr_in.proto_num});
      end else if ((state_ff == ST_PROBE) && !done) begin
         rd_addr = next_idx;
      end else begin
         rd_addr = probe_idx_ff;
      end

      wr       = '0;
      wr_addr  = probe_idx_ff;
      wr_entry = rd_entry;
      if (state_ff == ST_CLEAR) begin
         wr.valid_en  = 1'b1;
         wr.valid_bit = 1'b0;
         wr_addr      = clr_idx_ff;
      end else if (finish && hit) begin
         wr.data_en         = 1'b1;
         wr_entry.last_time = hdr_ff.time_stamp;
         wr_entry.pkt_count = rd_entry.pkt_count + COUNT_W'(1);
      end else if (finish && empty) begin
         wr.data_en           = 1'b1;
         wr.valid_en          = 1'b1;
         wr.valid_bit         = 1'b1;
         wr_entry.kind        = kind_ff;
         wr_entry.pkt_count   = COUNT_W'(1);
         wr_entry.last_time   = hdr_ff.time_stamp;
         wr_entry.first_time  = hdr_ff.time_stamp;
         wr_entry.ports_proto = {hdr_ff.src_port, hdr_ff.dst_port, hdr_ff.proto_num};
         wr_entry.addr_pair   = {hdr_ff.src_addr, hdr_ff.dst_addr};
      end

      rsp_in.hdr        = hdr_ff;
      rsp_in.nat_kind   = kind_ff;
      rsp_in.new_flow   = empty;
      rsp_in.table_full = !hit && !empty;
      if (hit) begin
         rsp_in.flow_start_time = rd_entry.first_time;
         rsp_in.flow_count      = rd_entry.pkt_count + COUNT_W'(1);
      end else if (empty) begin
         rsp_in.flow_start_time = hdr_ff.time_stamp;
         rsp_in.flow_count      = COUNT_W'(1);
      end else begin
         rsp_in.flow_start_time = '0;
         rsp_in.flow_count      = '0;
      end
   end

   nfct_flow_mem #(
      .ENTRIES (FLOW_ENTRIES),
      .IDX_W   (IDX_W)
   ) u_flow_mem (
      .clock    (clock),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .wr       (wr),
      .wr_entry (wr_entry),
      .rd_valid (rd_valid),
      .rd_entry (rd_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         pod_base_ff  <= POD_BASE_RST;
         pod_mask_ff  <= POD_MASK_RST;
         svc_base_ff  <= SVC_BASE_RST;
         svc_mask_ff  <= SVC_MASK_RST;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_POD_BASE: pod_base_ff <= csr_wdata;
               REG_POD_MASK: pod_mask_ff <= csr_wdata;
               REG_SVC_BASE: svc_base_ff <= csr_wdata;
               REG_SVC_MASK: svc_mask_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + IDX_W'(1);
               if (clr_idx_ff == LAST_IDX) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept && classified) begin
                  hdr_ff       <= hdr_in;
                  kind_ff      <= snat ? KIND_SNAT : KIND_DNAT;
                  probe_idx_ff <= rd_addr;
                  probe_cnt_ff <= '0;
                  state_ff     <= ST_PROBE;
               end
            end
            ST_PROBE: begin
               if (finish) begin
                  rsp_ff   <= rsp_in;
                  state_ff <= ST_IDLE;
               end else if (!done) begin
                  probe_idx_ff <= next_idx;
                  probe_cnt_ff <= probe_cnt_ff + IDX_W'(1);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.flow_count, rsp_ff.flow_start_time, rsp_ff.hdr};
   assign rsp_tuser  = {rsp_ff.table_full, rsp_ff.new_flow, rsp_ff.nat_kind};

endmodule

FILE: sv/nfct_flow_mem.sv
module nfct_flow_mem
   import nfct_pkg::*;
#(
   parameter int ENTRIES = 1024,
   parameter int IDX_W   = $clog2(ENTRIES)
) (
   input  logic             clock,
   input  logic [IDX_W-1:0] rd_addr,
   input  logic [IDX_W-1:0] wr_addr,
   input  mem_wr_type       wr,
   input  flow_entry_type   wr_entry,
   output logic             rd_valid,
   output flow_entry_type   rd_entry
);

   logic           valid_mem [ENTRIES];
   flow_entry_type entry_mem [ENTRIES];
   logic           rd_valid_ff;
   flow_entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr.valid_en) begin
         valid_mem[wr_addr] <= wr.valid_bit;
      end
      rd_valid_ff <= valid_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.data_en) begin
         entry_mem[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= entry_mem[rd_addr];
   end

   assign rd_valid = rd_valid_ff;
   assign rd_entry = rd_entry_ff;

endmodule

FILE: sv/nfct_checker.sv
module nfct_checker
   import nfct_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   // held result must not change
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // table clear runs right after reset
   assert property (@(posedge clock) $fell(reset) |-> !req_tready)
      else $error("request taken during table clear");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[1] && rsp_tuser[2]))
      else $error("new flow and table full together");

   // new flow starts at one packet, first seen equals packet time
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         (rsp_tdata[263:232] == 32'd1) && (rsp_tdata[231:168] == rsp_tdata[167:104]))
      else $error("bad new flow transaction");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> (rsp_tdata[263:232] == 32'd0) && (rsp_tdata[231:168] == 64'd0))
      else $error("table full transaction carries flow data");

endmodule

bind nat_flow_classifier_tracker nfct_checker u_nfct_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
